>>> src/wfpt_pkg.sv
// Shared constants for the wildcard fallback probability table.
// Request codes, key layout, stream widths and defaults; no dependencies.
package wfpt_pkg;

  // request kinds carried in s_tuser
  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_GET   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam int ACTION_W = 4;
  localparam int STATE_W  = 6;
  localparam int OBS_W    = 4;
  localparam int PROB_IN_W  = 18;
  localparam int PROB_W     = 17;
  localparam int REQ_W      = 2;
  // {action_id, action_any, state_id, state_any, obs_id, obs_any}
  localparam int KEY_W = ACTION_W + 1 + STATE_W + 1 + OBS_W + 1;

  // Q1.16 value for 1.0
  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(65536);

  localparam int PROBE_W = 3;
  localparam logic [PROBE_W-1:0] PROBE_LAST = 3'd7;

  // input payload: fields packed low to high, padded to bytes
  localparam int IN_FIELDS_W = KEY_W + PROB_IN_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = PROB_W + 2;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int TABLE_ENTRIES_DEFAULT = 64;

endpackage

>>> src/wildcard_fallback_probability_table.sv
// Wildcard fallback probability table: key CAM in flops, probability RAM.
// Uses wfpt_pkg for request codes, key layout and stream widths.
//
// Clear goes straight to the result; set probes the key as given, then writes;
// get probes one pattern per cycle, up to eight, then reads the RAM.
// One request at a time; the next is taken once the result is in the output
// register; the probe sequencer over the compares and m_tready set the rate.
// Synchronous reset empties the table (valid bits cleared) and drops m_tvalid.
module wildcard_fallback_probability_table #(
  parameter int TABLE_ENTRIES = wfpt_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // action_id[3:0], action_any[4], state_id[10:5], state_any[11],
  // obs_id[15:12], obs_any[16], prob_in[34:17], zero pad
  input  logic [wfpt_pkg::IN_DATA_W-1:0]   s_tdata,
  // req_type[1:0]
  input  logic [wfpt_pkg::REQ_W-1:0]       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // prob_out[16:0], found[17], table_full[18], zero pad
  output logic [wfpt_pkg::OUT_DATA_W-1:0]  m_tdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_SET_WR,
    ST_GET_RD,
    ST_DONE
  } state_t;

  state_t state;

  // latched request
  logic                          is_set;
  logic [wfpt_pkg::ACTION_W-1:0] action_q;
  logic                          action_any_q;
  logic [wfpt_pkg::STATE_W-1:0]  state_q;
  logic                          state_any_q;
  logic [wfpt_pkg::OBS_W-1:0]    obs_q;
  logic                          obs_any_q;
  logic [wfpt_pkg::PROB_W-1:0]   prob_q;
  logic [wfpt_pkg::PROBE_W-1:0]  probe;

  logic [TABLE_ENTRIES-1:0]      entry_valid;
  logic [wfpt_pkg::KEY_W-1:0]    entry_key [TABLE_ENTRIES];
  logic [wfpt_pkg::PROB_W-1:0]   entry_prob [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0]      match_vec;
  logic [TABLE_ENTRIES-1:0]      match_q;
  logic [wfpt_pkg::PROB_W-1:0]   rd_data;
  logic                          res_found;
  logic                          res_full;

  logic                          pa, ps, po;
  logic [wfpt_pkg::KEY_W-1:0]    probe_key;
  logic                          hit;
  logic                          hit_q;
  logic [IDX_W-1:0]              hit_idx;
  logic [IDX_W-1:0]              free_idx;
  logic                          free_any;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_idx;

  logic [wfpt_pkg::PROB_IN_W-1:0] prob_raw;
  logic [wfpt_pkg::PROB_W-1:0]    prob_clamped;

  // keys are unique among valid entries, so the match vector is one-hot
  function automatic logic [IDX_W-1:0] onehot_idx(input logic [TABLE_ENTRIES-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (vec[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [IDX_W-1:0] lowest_free(input logic [TABLE_ENTRIES-1:0] valid);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  assign s_tready = (state == ST_IDLE);

  // clamp signed Q1.16 to 0..1.0
  assign prob_raw = s_tdata[wfpt_pkg::KEY_W +: wfpt_pkg::PROB_IN_W];
  always_comb begin
    if (prob_raw[wfpt_pkg::PROB_IN_W-1]) begin
      prob_clamped = '0;
    end else if (prob_raw[wfpt_pkg::PROB_W-1:0] > wfpt_pkg::PROB_ONE) begin
      prob_clamped = wfpt_pkg::PROB_ONE;
    end else begin
      prob_clamped = prob_raw[wfpt_pkg::PROB_W-1:0];
    end
  end

  // probe p: action specific on bit 1, state on bit 2, observation on bit 0
  assign pa = action_any_q | ~probe[1];
  assign ps = state_any_q  | ~probe[2];
  assign po = obs_any_q    | ~probe[0];
  assign probe_key = {pa ? {wfpt_pkg::ACTION_W{1'b0}} : action_q, pa,
                      ps ? {wfpt_pkg::STATE_W{1'b0}}  : state_q,  ps,
                      po ? {wfpt_pkg::OBS_W{1'b0}}    : obs_q,    po};

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_vec[i] = entry_valid[i] && (entry_key[i] == probe_key);
    end
  end

  assign hit      = |match_vec;
  assign hit_q    = |match_q;
  assign hit_idx  = onehot_idx(match_q);
  assign free_any = ~&entry_valid;
  assign free_idx = lowest_free(entry_valid);
  assign wr_en    = (state == ST_SET_WR) && (hit_q || free_any);
  assign wr_idx   = hit_q ? hit_idx : free_idx;

  // key and probability storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_key[wr_idx]  <= probe_key;
      entry_prob[wr_idx] <= prob_q;
    end
    if (state == ST_GET_RD) begin
      rd_data <= entry_prob[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_valid <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // ST_DONE drives m_tvalid itself
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            action_q     <= s_tdata[3:0];
            action_any_q <= s_tdata[4];
            state_q      <= s_tdata[10:5];
            state_any_q  <= s_tdata[11];
            obs_q        <= s_tdata[15:12];
            obs_any_q    <= s_tdata[16];
            prob_q       <= prob_clamped;
            res_found    <= 1'b0;
            res_full     <= 1'b0;
            is_set       <= (s_tuser == wfpt_pkg::REQ_SET);
            case (s_tuser)
              wfpt_pkg::REQ_SET: begin
                // all parts as given
                probe <= wfpt_pkg::PROBE_LAST;
                state <= ST_PROBE;
              end
              wfpt_pkg::REQ_GET: begin
                probe <= '0;
                state <= ST_PROBE;
              end
              wfpt_pkg::REQ_CLEAR: begin
                entry_valid <= '0;
                state       <= ST_DONE;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_PROBE: begin
          match_q <= match_vec;
          if (is_set) begin
            state <= ST_SET_WR;
          end else if (hit) begin
            state <= ST_GET_RD;
          end else if (probe == wfpt_pkg::PROBE_LAST) begin
            state <= ST_DONE;
          end else begin
            probe <= probe + 1'b1;
          end
        end
        ST_SET_WR: begin
          if (wr_en) begin
            entry_valid[wr_idx] <= 1'b1;
          end
          res_full <= !(hit_q || free_any);
          state    <= ST_DONE;
        end
        ST_GET_RD: begin
          res_found <= 1'b1;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= wfpt_pkg::OUT_DATA_W'({res_full, res_found,
                                               res_found ? rd_data
                                                         : {wfpt_pkg::PROB_W{1'b0}}});
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
